/* rtl/core/query_pair_percent_decoder_top_defines.svh */
// Assertion macros for the query pair percent decoder checker.
// Depends on nothing; included by the checker file only.
`ifndef QUERY_PAIR_PERCENT_DECODER_TOP_DEFINES_SVH
`define QUERY_PAIR_PERCENT_DECODER_TOP_DEFINES_SVH

// Plain property check, clocked and disabled in reset.
`define QPD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Overlapping implication check, clocked and disabled in reset.
`define QPD_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/core/qpd_pkg.sv */
// Shared types and constants of the query pair percent decoder.
// Depends on nothing.
package qpd_pkg;

  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_PCT = 8'h25;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int NREC    = 3;
  localparam int RIDX_W  = $clog2(NREC);

  typedef enum logic [1:0] {
    KIND_KEY         = 2'd0,
    KIND_VALUE       = 2'd1,
    KIND_VALUE_BEGIN = 2'd2,
    KIND_PAIR_END    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       has_value;
    logic       done;
  } rec_t;

  typedef struct packed {
    logic [RIDX_W-1:0]    cnt;
    rec_t [NREC-1:0]      rec;
  } cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h41 + 8'd10;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h61 + 8'd10;
    return v[3:0];
  endfunction

endpackage

/* rtl/core/qpd_front.sv */
// Front end: accepts raw query bytes, tracks escape and key/value state,
// and builds a command of up to three records. Depends on qpd_pkg.
module qpd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         in_byte_i,
  input  logic               is_end_i,
  output logic               push_o,
  output qpd_pkg::cmd_t      cmd_o
);

  qpd_pkg::esc_e phase_q, phase_d;
  logic [7:0]    held_q, held_d;
  logic          in_value_q, in_value_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= qpd_pkg::ESC_NONE;
      held_q     <= 8'h00;
      in_value_q <= 1'b0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      held_q     <= held_d;
      in_value_q <= in_value_d;
    end
  end

  // Next state.
  always_comb begin
    logic brk;
    brk        = 1'b1;
    phase_d    = phase_q;
    held_d     = held_q;
    in_value_d = in_value_q;
    if (is_end_i) begin
      phase_d    = qpd_pkg::ESC_NONE;
      held_d     = 8'h00;
      in_value_d = 1'b0;
    end else begin
      unique case (phase_q)
        qpd_pkg::ESC_PCT: begin
          if (qpd_pkg::is_hex(in_byte_i)) begin
            phase_d = qpd_pkg::ESC_DIGIT;
            held_d  = in_byte_i;
            brk     = 1'b0;
          end
        end
        qpd_pkg::ESC_DIGIT: begin
          if (qpd_pkg::is_hex(in_byte_i)) begin
            phase_d = qpd_pkg::ESC_NONE;
            held_d  = 8'h00;
            brk     = 1'b0;
          end
        end
        default: ;
      endcase
      if (brk) begin
        held_d  = 8'h00;
        phase_d = (in_byte_i == qpd_pkg::CH_PCT) ? qpd_pkg::ESC_PCT : qpd_pkg::ESC_NONE;
        if (in_byte_i == qpd_pkg::CH_AMP) in_value_d = 1'b0;
        else if (in_byte_i == qpd_pkg::CH_EQ) in_value_d = 1'b1;
      end
    end
  end

  // Records.
  always_comb begin
    logic [qpd_pkg::RIDX_W-1:0] n;
    logic                       flush_pct;
    logic                       flush_held;
    logic                       do_plain;
    qpd_pkg::kind_e             dkind;
    qpd_pkg::rec_t              r;
    n          = '0;
    flush_pct  = 1'b0;
    flush_held = 1'b0;
    do_plain   = 1'b0;
    dkind      = in_value_q ? qpd_pkg::KIND_VALUE : qpd_pkg::KIND_KEY;
    r          = '0;
    cmd_o      = '0;

    unique case (phase_q)
      qpd_pkg::ESC_PCT: begin
        flush_pct = is_end_i || !qpd_pkg::is_hex(in_byte_i);
        do_plain  = !is_end_i && !qpd_pkg::is_hex(in_byte_i);
      end
      qpd_pkg::ESC_DIGIT: begin
        flush_pct  = is_end_i || !qpd_pkg::is_hex(in_byte_i);
        flush_held = flush_pct;
        do_plain   = !is_end_i && !qpd_pkg::is_hex(in_byte_i);
      end
      default: begin
        do_plain = !is_end_i;
      end
    endcase

    if (flush_pct) begin
      r = '{data: qpd_pkg::CH_PCT, kind: dkind, has_value: 1'b0, done: 1'b0};
      cmd_o.rec[n] = r;
      n = n + 1'b1;
    end
    if (flush_held) begin
      r = '{data: held_q, kind: dkind, has_value: 1'b0, done: 1'b0};
      cmd_o.rec[n] = r;
      n = n + 1'b1;
    end
    if (is_end_i) begin
      r = '{data: 8'h00, kind: qpd_pkg::KIND_PAIR_END, has_value: in_value_q, done: 1'b1};
      cmd_o.rec[n] = r;
      n = n + 1'b1;
    end else if (phase_q == qpd_pkg::ESC_DIGIT && qpd_pkg::is_hex(in_byte_i)) begin
      r = '{data: {qpd_pkg::hex_val(held_q), qpd_pkg::hex_val(in_byte_i)}, kind: dkind,
            has_value: 1'b0, done: 1'b0};
      cmd_o.rec[n] = r;
      n = n + 1'b1;
    end else if (do_plain && in_byte_i != qpd_pkg::CH_PCT) begin
      if (in_byte_i == qpd_pkg::CH_AMP) begin
        r = '{data: 8'h00, kind: qpd_pkg::KIND_PAIR_END, has_value: in_value_q, done: 1'b0};
      end else if (in_byte_i == qpd_pkg::CH_EQ) begin
        r = '{data: 8'h00, kind: qpd_pkg::KIND_VALUE_BEGIN, has_value: 1'b0, done: 1'b0};
      end else begin
        r = '{data: in_byte_i, kind: dkind, has_value: 1'b0, done: 1'b0};
      end
      cmd_o.rec[n] = r;
      n = n + 1'b1;
    end
    cmd_o.cnt = n;
  end

  assign push_o = fire_i && (cmd_o.cnt != '0);

endmodule

/* rtl/core/qpd_queue.sv */
// Command queue between front end and back end.
// Depends on qpd_pkg.
module qpd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  qpd_pkg::cmd_t  cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output qpd_pkg::cmd_t  cmd_o
);

  qpd_pkg::cmd_t               mem_q [qpd_pkg::QDEPTH];
  logic [qpd_pkg::QPTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [qpd_pkg::QCNT_W-1:0]  cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + {{(qpd_pkg::QCNT_W-1){1'b0}}, push_i}
                  - {{(qpd_pkg::QCNT_W-1){1'b0}}, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign full_o  = (cnt_q == qpd_pkg::QCNT_W'(qpd_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];

endmodule

/* rtl/core/qpd_back.sv */
// Back end: walks the records of the head command into the output register.
// Depends on qpd_pkg.
module qpd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  qpd_pkg::cmd_t  cmd_i,
  output logic           pop_o,
  input  logic           ready_i,
  output logic           valid_o,
  output logic           last_o,
  output qpd_pkg::rec_t  rec_o
);

  logic [qpd_pkg::RIDX_W-1:0] idx_q, idx_d;
  logic                       valid_q, valid_d;
  logic                       last_q;
  qpd_pkg::rec_t              rec_q;
  logic                       adv;
  logic                       is_last;

  assign adv     = valid_i && (!valid_q || ready_i);
  assign is_last = (idx_q == cmd_i.cnt - 1'b1);
  assign pop_o   = adv && is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (adv) begin
      idx_d   = is_last ? '0 : idx_q + 1'b1;
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rec_q  <= cmd_i.rec[idx_q];
      last_q <= is_last;
    end
  end

  assign valid_o = valid_q;
  assign last_o  = last_q;
  assign rec_o   = rec_q;

endmodule

/* rtl/core/query_pair_percent_decoder_top.sv */
// Query string pair splitter and percent decoder, top level.
// Depends on qpd_pkg, qpd_front, qpd_queue and qpd_back.
//
// One raw query byte (or an end marker) is taken per cycle while the four-entry
// command queue has room; the front end decodes it in that cycle and queues up to
// three records. The back end drives one record per cycle from its output register
// while the output is not stalled; each record passes through a queue entry and then
// that output register. Sustained input rate is one item per cycle as long as
// items average at most one record and the output is not stalled.
module query_pair_percent_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] is_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] pair_has_value,
                                      // [9] query_done, [15:10] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] record_kind
  output logic        m_axis_tlast    // last_of_run
);

  logic          full;
  logic          in_fire;
  logic          push;
  qpd_pkg::cmd_t push_cmd;
  logic          head_valid;
  qpd_pkg::cmd_t head_cmd;
  logic          pop;
  qpd_pkg::rec_t rec;

  assign s_axis_tready = !full;
  assign in_fire       = s_axis_tvalid && !full;

  qpd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (in_fire),
    .in_byte_i (s_axis_tdata),
    .is_end_i  (s_axis_tuser),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  qpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  qpd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .cmd_i   (head_cmd),
    .pop_o   (pop),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .last_o  (m_axis_tlast),
    .rec_o   (rec)
  );

  assign m_axis_tdata = {6'b0, rec.done, rec.has_value, rec.data};
  assign m_axis_tuser = rec.kind;

endmodule

/* rtl/core/qpd_checker.sv */
// Port-level checks for the query pair percent decoder, bound to the top level.
// Depends on qpd_pkg and query_pair_percent_decoder_top_defines.svh.
`include "query_pair_percent_decoder_top_defines.svh"

module qpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  `QPD_ASSERT(a_out_hold, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid),
    "output dropped while stalled")
  `QPD_ASSERT_IMPL(a_done_is_end, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[9],
    m_axis_tuser == qpd_pkg::KIND_PAIR_END && m_axis_tlast,
    "query_done off a final pair end")
  `QPD_ASSERT_IMPL(a_flags_pair_end, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser != qpd_pkg::KIND_PAIR_END,
    m_axis_tdata[15:8] == 8'h00,
    "flags set on a non pair end record")
  `QPD_ASSERT_IMPL(a_marker_zero, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == qpd_pkg::KIND_PAIR_END ||
                      m_axis_tuser == qpd_pkg::KIND_VALUE_BEGIN),
    m_axis_tdata[7:0] == 8'h00,
    "marker record carries a byte")

endmodule

bind query_pair_percent_decoder_top qpd_checker u_qpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

/* test/query_pair_percent_decoder_top_tb.sv */
// Self-checking testbench of the query pair percent decoder top level.
// Drives raw query bytes and end markers, predicts records; depends on qpd_pkg.
`timescale 1ns / 1ps

module query_pair_percent_decoder_top_tb;

  localparam int PHASE_ITEMS    = 12;
  localparam int PRESSURE_ITEMS = 20;
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES   = 20;
  localparam int CYCLE_LIMIT    = 100000;

  typedef struct packed {
    logic [7:0]     data;
    qpd_pkg::kind_e kind;
    logic           has_value;
    logic           done;
    logic           last;
  } decoded_rec_t;

  typedef enum {BY_MODEL, NO_RESULT, ONE_RESULT} row_check_e;

  typedef struct {
    logic [7:0]   chr;
    logic         is_end;
    row_check_e   mode;
    decoded_rec_t typed;
  } dir_row_t;

  typedef struct {
    logic [7:0] chr;
    logic       is_end;
  } query_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  qpd_pkg::esc_e esc_state;
  logic [7:0]    held_char;
  logic          in_value;
  decoded_rec_t  byte_records[$];
  decoded_rec_t  pending_records[$];
  dir_row_t      dir_rows[$];
  query_item_t   chunk_items[$];
  int            send_idle_pct;
  int            recv_stall_pct;
  int            mismatch_count;
  int            cycle_count;
  bit            pressure_req;
  bit            pressure_served;

  query_pair_percent_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic decoded_rec_t mk(input logic [7:0] d, input qpd_pkg::kind_e k,
                                      input logic hv, input logic dn, input logic lst);
    decoded_rec_t r;
    r.data      = d;
    r.kind      = k;
    r.has_value = hv;
    r.done      = dn;
    r.last      = lst;
    return r;
  endfunction

  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
      return 1'b1;
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h41 + 8'd10);
      return 1'b1;
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h61 + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == qpd_pkg::CH_AMP || c == qpd_pkg::CH_EQ || c == qpd_pkg::CH_PCT);
    return c;
  endfunction

  task automatic emit(input logic [7:0] d, input qpd_pkg::kind_e k, input logic hv,
                      input logic dn);
    byte_records.push_back(mk(d, k, hv, dn, 1'b0));
  endtask

  task automatic emit_data(input logic [7:0] c);
    emit(c, in_value ? qpd_pkg::KIND_VALUE : qpd_pkg::KIND_KEY, 1'b0, 1'b0);
  endtask

  task automatic plain_char(input logic [7:0] c);
    if (c == qpd_pkg::CH_AMP) begin
      emit(8'h00, qpd_pkg::KIND_PAIR_END, in_value, 1'b0);
      in_value = 1'b0;
    end else if (c == qpd_pkg::CH_EQ) begin
      emit(8'h00, qpd_pkg::KIND_VALUE_BEGIN, 1'b0, 1'b0);
      in_value = 1'b1;
    end else if (c == qpd_pkg::CH_PCT) begin
      esc_state = qpd_pkg::ESC_PCT;
    end else begin
      emit_data(c);
    end
  endtask

  task automatic flush_escape();
    if (esc_state == qpd_pkg::ESC_PCT || esc_state == qpd_pkg::ESC_DIGIT)
      emit_data(qpd_pkg::CH_PCT);
    if (esc_state == qpd_pkg::ESC_DIGIT) emit_data(held_char);
    esc_state = qpd_pkg::ESC_NONE;
    held_char = 8'h00;
  endtask

  task automatic decode_query_byte(input logic [7:0] c, input logic is_end);
    logic [3:0] hi;
    logic [3:0] lo;
    logic       c_hex;
    byte_records.delete();
    c_hex = hex_nibble(c, lo);
    if (is_end) begin
      flush_escape();
      emit(8'h00, qpd_pkg::KIND_PAIR_END, in_value, 1'b1);
      in_value = 1'b0;
    end else if (esc_state == qpd_pkg::ESC_PCT) begin
      if (c_hex) begin
        held_char = c;
        esc_state = qpd_pkg::ESC_DIGIT;
      end else begin
        flush_escape();
        plain_char(c);
      end
    end else if (esc_state == qpd_pkg::ESC_DIGIT) begin
      if (c_hex) begin
        void'(hex_nibble(held_char, hi));
        emit_data({hi, lo});
        esc_state = qpd_pkg::ESC_NONE;
        held_char = 8'h00;
      end else begin
        flush_escape();
        plain_char(c);
      end
    end else begin
      esc_state = qpd_pkg::ESC_NONE;
      plain_char(c);
    end
    if (byte_records.size() > 0) byte_records[byte_records.size() - 1].last = 1'b1;
  endtask

  task automatic add_row(input logic [7:0] chr, input logic is_end, input row_check_e mode,
                         input decoded_rec_t typed);
    dir_row_t r;
    r.chr    = chr;
    r.is_end = is_end;
    r.mode   = mode;
    r.typed  = typed;
    dir_rows.push_back(r);
  endtask

  task automatic add_item(input logic [7:0] chr, input logic is_end);
    query_item_t it;
    it.chr    = chr;
    it.is_end = is_end;
    chunk_items.push_back(it);
  endtask

  // Build one short piece of query text, mostly well formed.
  task automatic build_chunk();
    int pick;
    int n;
    chunk_items.delete();
    pick = $urandom_range(99);
    if (pick < 30) begin
      n = $urandom_range(4, 1);
      repeat (n) add_item(text_char(), 1'b0);
    end else if (pick < 45) begin
      add_item(qpd_pkg::CH_EQ, 1'b0);
    end else if (pick < 57) begin
      add_item(qpd_pkg::CH_AMP, 1'b0);
    end else if (pick < 75) begin
      add_item(qpd_pkg::CH_PCT, 1'b0);
      add_item(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
      add_item(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
    end else if (pick < 85) begin
      add_item(qpd_pkg::CH_PCT, 1'b0);
      if ($urandom_range(1))
        add_item(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
      case ($urandom_range(4))
        0: add_item(qpd_pkg::CH_AMP, 1'b0);
        1: add_item(qpd_pkg::CH_EQ, 1'b0);
        2: add_item(qpd_pkg::CH_PCT, 1'b0);
        3: add_item(8'($urandom_range(255)), 1'b1);
        default: add_item(8'($urandom_range(255)), 1'b0);
      endcase
    end else if (pick < 92) begin
      add_item(8'($urandom_range(255)), 1'b1);
    end else begin
      add_item(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic send_item(input logic [7:0] c, input logic is_end);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= is_end;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic send_predicted(input logic [7:0] c, input logic is_end);
    send_item(c, is_end);
    decode_query_byte(c, is_end);
    foreach (byte_records[i]) pending_records.push_back(byte_records[i]);
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(negedge clk_i) begin : record_monitor
    decoded_rec_t got;
    decoded_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = mk(m_axis_tdata[7:0], qpd_pkg::kind_e'(m_axis_tuser), m_axis_tdata[8],
               m_axis_tdata[9], m_axis_tlast);
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record: expected none, actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_records.pop_front();
        check_field("out_byte", want.data, got.data);
        check_field("record_kind", want.kind, got.kind);
        check_field("pair_has_value", want.has_value, got.has_value);
        check_field("query_done", want.done, got.done);
        check_field("last_of_run", want.last, got.last);
      end
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (pressure_req && !pressure_served) begin
        hold_left       = HOLD_CYCLES;
        pressure_served = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int sent;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = 8'h00;
    s_axis_tuser    = 1'b0;
    esc_state       = qpd_pkg::ESC_NONE;
    held_char       = 8'h00;
    in_value        = 1'b0;
    mismatch_count  = 0;
    pressure_req    = 1'b0;
    pressure_served = 1'b0;
    send_idle_pct   = 19;
    recv_stall_pct  = 19;

    add_row(8'h00, 1'b1, ONE_RESULT, mk(8'h00, qpd_pkg::KIND_PAIR_END, 1'b0, 1'b1, 1'b1));
    add_row(8'h61, 1'b0, ONE_RESULT, mk(8'h61, qpd_pkg::KIND_KEY, 1'b0, 1'b0, 1'b1));
    add_row(qpd_pkg::CH_EQ, 1'b0, ONE_RESULT,
            mk(8'h00, qpd_pkg::KIND_VALUE_BEGIN, 1'b0, 1'b0, 1'b1));
    add_row(qpd_pkg::CH_PCT, 1'b0, NO_RESULT, '0);
    add_row(8'h34, 1'b0, NO_RESULT, '0);
    add_row(8'h31, 1'b0, BY_MODEL, '0);
    add_row(qpd_pkg::CH_EQ, 1'b0, ONE_RESULT,
            mk(8'h00, qpd_pkg::KIND_VALUE_BEGIN, 1'b0, 1'b0, 1'b1));
    add_row(8'hFF, 1'b0, ONE_RESULT, mk(8'hFF, qpd_pkg::KIND_VALUE, 1'b0, 1'b0, 1'b1));
    add_row(8'h00, 1'b0, ONE_RESULT, mk(8'h00, qpd_pkg::KIND_VALUE, 1'b0, 1'b0, 1'b1));
    add_row(qpd_pkg::CH_AMP, 1'b0, ONE_RESULT,
            mk(8'h00, qpd_pkg::KIND_PAIR_END, 1'b1, 1'b0, 1'b1));
    add_row(qpd_pkg::CH_AMP, 1'b0, ONE_RESULT,
            mk(8'h00, qpd_pkg::KIND_PAIR_END, 1'b0, 1'b0, 1'b1));
    add_row(qpd_pkg::CH_PCT, 1'b0, NO_RESULT, '0);
    add_row(8'h46, 1'b0, NO_RESULT, '0);
    add_row(8'h66, 1'b0, BY_MODEL, '0);
    add_row(qpd_pkg::CH_PCT, 1'b0, NO_RESULT, '0);
    add_row(8'h67, 1'b0, BY_MODEL, '0);
    add_row(qpd_pkg::CH_PCT, 1'b0, NO_RESULT, '0);
    add_row(8'h61, 1'b0, NO_RESULT, '0);
    add_row(qpd_pkg::CH_AMP, 1'b0, BY_MODEL, '0);
    add_row(qpd_pkg::CH_PCT, 1'b0, NO_RESULT, '0);
    add_row(qpd_pkg::CH_PCT, 1'b0, BY_MODEL, '0);
    add_row(8'h30, 1'b0, NO_RESULT, '0);
    add_row(qpd_pkg::CH_EQ, 1'b0, BY_MODEL, '0);
    add_row(qpd_pkg::CH_PCT, 1'b0, NO_RESULT, '0);
    add_row(8'hA5, 1'b1, BY_MODEL, '0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].chr, dir_rows[i].is_end);
      decode_query_byte(dir_rows[i].chr, dir_rows[i].is_end);
      case (dir_rows[i].mode)
        BY_MODEL: begin
          foreach (byte_records[j]) pending_records.push_back(byte_records[j]);
        end
        ONE_RESULT: pending_records.push_back(dir_rows[i].typed);
        default: ;
      endcase
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_chunk();
        foreach (chunk_items[i]) begin
          send_predicted(chunk_items[i].chr, chunk_items[i].is_end);
          sent++;
        end
      end
    end

    // Hold the output off while the sender keeps pushing text.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_req   = 1'b1;
    for (int i = 0; i < PRESSURE_ITEMS; i++) send_predicted(text_char(), 1'b0);
    send_predicted(8'h00, 1'b1);
    s_axis_tvalid <= 1'b0;

    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
